// ===== rtl/flvs_pkg.sv =====
// shared types and constants for the flash log variable store
`default_nettype none
package flvs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [15:0] ERASED_HW    = 16'hFFFF;
    localparam logic [15:0] DUMMY_LINK   = 16'h0400;
    localparam logic [15:0] RECEIVE_MARK = 16'hADDE;
    localparam logic [15:0] VALID_MARK   = 16'hDEC0;
    localparam logic [15:0] RSVD_LOW     = 16'h0000;
    localparam logic [15:0] RSVD_HIGH    = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_ADDR  = 3'd4,
        ST_TOO_LARGE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        K_DATA,
        K_COMMIT,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [15:0] vaddress;
        logic [7:0]  size_bytes;
        logic [15:0] data_word;
    } cmd_t;

    typedef struct packed {
        logic init_done;
    } back_stat_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_EMIT,
        S_RD_VA_W,
        S_RD_HD_W,
        S_RD_ISSUE,
        S_RD_WD_W,
        S_WR_CHECK,
        S_WR_BUF,
        S_WR_DATA,
        S_WR_HDR1,
        S_WR_HDR0,
        S_CP_MARK,
        S_CP_VA_W,
        S_CP_HD_W,
        S_CP_SRCH,
        S_CP_SRCH_VA_W,
        S_CP_SRCH_HD_W,
        S_CP_COPY_RD,
        S_CP_COPY_W,
        S_CP_HDR1,
        S_CP_HDR0,
        S_CP_LINK,
        S_CP_FMT,
        S_CP_VALID
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/flvs_front.sv =====
// front end: takes input words and classifies them into command records
`default_nettype none
module flvs_front
    import flvs_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = 64
) (
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    input  wire back_stat_t back_stat,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_wdata
);

    logic [15:0] va;
    logic [7:0]  sz;

    assign va = s_tdata[15:0];
    assign sz = s_tdata[23:16];

    assign s_tready = back_stat.init_done && !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_wdata.vaddress   = va;
        q_wdata.size_bytes = sz;
        q_wdata.data_word  = s_tdata[39:24];
        if (!s_tuser) begin
            q_wdata.kind = K_READ;
        end else if (s_tlast) begin
            q_wdata.kind = K_COMMIT;
        end else begin
            q_wdata.kind = K_DATA;
        end
        // address check ranks above the size check
        if (va == RSVD_LOW || va == RSVD_HIGH) begin
            q_wdata.status = ST_BAD_ADDR;
        end else if (9'(sz) > 9'(MAX_VALUE_BYTES)) begin
            q_wdata.status = ST_TOO_LARGE;
        end else begin
            q_wdata.status = ST_OK;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/flvs_queue.sv =====
// short command queue between front and back
`default_nettype none
module flvs_queue
    import flvs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t wdata,
    input  wire logic pop,
    output cmd_t      rdata,
    output logic      full,
    output logic      empty
);

    cmd_t                store [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = cnt_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store[rptr_reg];

    always_comb begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QUEUE_AW + 1)'(do_push) - (QUEUE_AW + 1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/flvs_back.sv =====
// back end: page store, write buffer and the read, append and compaction sequencer
`default_nettype none
module flvs_back
    import flvs_pkg::*;
#(
    parameter int PAGE_HALFWORDS  = 512,
    parameter int MAX_VALUE_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        q_rdata,
    input  wire logic        q_empty,
    output logic             q_pop,
    output back_stat_t       back_stat,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    localparam int OW  = $clog2(PAGE_HALFWORDS);
    localparam int FW  = OW + 1;
    localparam int OFW = $clog2(PAGE_HALFWORDS + 264);
    localparam int AW  = $clog2(2 * PAGE_HALFWORDS);
    localparam int GW  = OW + 1;
    localparam int WB  = (MAX_VALUE_BYTES + 1) / 2;
    localparam int WBW = (WB > 1) ? $clog2(WB) : 1;
    localparam int CW  = $clog2(WB + 1);
    localparam logic [OFW-1:0] PAGE_OF = OFW'(PAGE_HALFWORDS);

    // page store and write buffer
    logic [15:0] mem [2 * PAGE_HALFWORDS];
    logic [15:0] wbuf [WB];
    logic [15:0] mem_q_reg;
    logic        oob_reg;
    logic [15:0] buf_q_reg;
    logic [15:0] hw;

    logic           rd_page, wr_en, wr_page, buf_we;
    logic [OFW-1:0] rd_off, wr_off;
    logic [15:0]    wr_data, buf_wdata;
    logic [WBW-1:0] buf_waddr, buf_raddr;
    logic [AW-1:0]  rd_addr, wr_addr;

    state_t         state_reg, state_next, ret_reg, ret_next;
    cmd_t           cmd_reg, cmd_next;
    logic           active_reg, active_next;
    logic [OW-1:0]  newest_reg, newest_next;
    logic [FW-1:0]  free_reg, free_next;
    logic [CW-1:0]  bcnt_reg, bcnt_next;
    logic [OW-1:0]  r_reg, r_next;
    logic [GW-1:0]  guard_reg, guard_next;
    logic           match_reg, match_next;
    logic [7:0]     idx_reg, idx_next;
    logic           compacted_reg, compacted_next;
    logic [OW-1:0]  wprev_reg, wprev_next;
    logic [FW-1:0]  wptr_reg, wptr_next;
    logic [OFW-1:0] s_reg, s_next;
    logic [15:0]    vac_reg, vac_next;
    logic [15:0]    hdrc_reg, hdrc_next;
    logic [OW-1:0]  sweep_reg, sweep_next;
    logic           spage_reg, spage_next;
    status_t        res_st_reg, res_st_next;
    logic [15:0]    res_word_reg, res_word_next;
    logic           res_fin_reg, res_fin_next;

    logic           mo_valid_reg;
    logic [15:0]    mo_word_reg;
    logic [2:0]     mo_st_reg;
    logic           mo_last_reg;
    logic           out_free, out_load;

    logic [7:0]     n_cmd, n_c, lp;
    logic [OFW-1:0] r_of;
    logic [15:0]    word_m;

    assign hw       = oob_reg ? ERASED_HW : mem_q_reg;
    assign out_free = !mo_valid_reg || m_tready;
    assign n_cmd    = 8'((9'(cmd_reg.size_bytes) + 9'd1) >> 1);
    assign n_c      = 8'((9'(hdrc_reg[15:8]) + 9'd1) >> 1);
    assign r_of     = OFW'(r_reg);
    assign back_stat.init_done = state_reg != S_INIT;

    assign m_tvalid = mo_valid_reg;
    assign m_tdata  = mo_word_reg;
    assign m_tuser  = mo_st_reg;
    assign m_tlast  = mo_last_reg;

    assign rd_addr = rd_page ? AW'(rd_off + PAGE_OF) : AW'(rd_off);
    assign wr_addr = wr_page ? AW'(wr_off + PAGE_OF) : AW'(wr_off);

    always_ff @(posedge aclk) begin
        if (wr_en && wr_off < PAGE_OF) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
        oob_reg   <= rd_off >= PAGE_OF;
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            wbuf[buf_waddr] <= buf_wdata;
        end
        buf_q_reg <= wbuf[buf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            ret_reg       <= S_IDLE;
            active_reg    <= 1'b0;
            newest_reg    <= '0;
            free_reg      <= FW'(4);
            bcnt_reg      <= '0;
            sweep_reg     <= '0;
            spage_reg     <= 1'b0;
            compacted_reg <= 1'b0;
            r_reg         <= '0;
            guard_reg     <= '0;
            match_reg     <= 1'b0;
            idx_reg       <= '0;
            wprev_reg     <= '0;
            wptr_reg      <= '0;
            s_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            active_reg    <= active_next;
            newest_reg    <= newest_next;
            free_reg      <= free_next;
            bcnt_reg      <= bcnt_next;
            sweep_reg     <= sweep_next;
            spage_reg     <= spage_next;
            compacted_reg <= compacted_next;
            r_reg         <= r_next;
            guard_reg     <= guard_next;
            match_reg     <= match_next;
            idx_reg       <= idx_next;
            wprev_reg     <= wprev_next;
            wptr_reg      <= wptr_next;
            s_reg         <= s_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        vac_reg      <= vac_next;
        hdrc_reg     <= hdrc_next;
        res_st_reg   <= res_st_next;
        res_word_reg <= res_word_next;
        res_fin_reg  <= res_fin_next;
    end

    // output register parts the sequencer from the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mo_valid_reg <= 1'b0;
        end else if (out_load) begin
            mo_valid_reg <= 1'b1;
        end else if (m_tready) begin
            mo_valid_reg <= 1'b0;
        end
        if (out_load) begin
            mo_word_reg <= res_word_reg;
            mo_st_reg   <= res_st_reg;
            mo_last_reg <= res_fin_reg;
        end
    end

    always_comb begin
        word_m = hw;
        if (idx_reg == n_cmd - 8'd1 && cmd_reg.size_bytes[0]) begin
            word_m = {8'h00, hw[7:0]};
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        active_next    = active_reg;
        newest_next    = newest_reg;
        free_next      = free_reg;
        bcnt_next      = bcnt_reg;
        r_next         = r_reg;
        guard_next     = guard_reg;
        match_next     = match_reg;
        idx_next       = idx_reg;
        compacted_next = compacted_reg;
        wprev_next     = wprev_reg;
        wptr_next      = wptr_reg;
        s_next         = s_reg;
        vac_next       = vac_reg;
        hdrc_next      = hdrc_reg;
        sweep_next     = sweep_reg;
        spage_next     = spage_reg;
        res_st_next    = res_st_reg;
        res_word_next  = res_word_reg;
        res_fin_next   = res_fin_reg;
        q_pop     = 1'b0;
        out_load  = 1'b0;
        rd_page   = active_reg;
        rd_off    = OFW'(newest_reg);
        wr_en     = 1'b0;
        wr_page   = active_reg;
        wr_off    = '0;
        wr_data   = ERASED_HW;
        buf_we    = 1'b0;
        buf_waddr = bcnt_reg[WBW-1:0];
        buf_wdata = q_rdata.data_word;
        buf_raddr = idx_reg[WBW-1:0];
        lp        = hdrc_reg[7:0];

        case (state_reg)
            // clearing pass: formats both pages, page 0 marked valid
            S_INIT: begin
                wr_en   = 1'b1;
                wr_page = spage_reg;
                wr_off  = OFW'(sweep_reg);
                if (sweep_reg == OW'(0)) begin
                    wr_data = RSVD_LOW;
                end else if (sweep_reg == OW'(1)) begin
                    wr_data = DUMMY_LINK;
                end else if (sweep_reg == OW'(3) && !spage_reg) begin
                    wr_data = VALID_MARK;
                end
                if (sweep_reg == OW'(PAGE_HALFWORDS - 1)) begin
                    sweep_next = '0;
                    spage_next = 1'b1;
                    if (spage_reg) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_rdata;
                    res_word_next = '0;
                    res_fin_next  = 1'b1;
                    res_st_next   = q_rdata.status;
                    ret_next      = S_IDLE;
                    case (q_rdata.kind)
                        K_DATA, K_COMMIT: begin
                            if (bcnt_reg < CW'(WB)) begin
                                buf_we    = 1'b1;
                                bcnt_next = bcnt_reg + 1'b1;
                            end
                            if (q_rdata.kind == K_COMMIT) begin
                                bcnt_next = '0;
                                if (q_rdata.status != ST_OK) begin
                                    state_next = S_EMIT;
                                end else begin
                                    compacted_next = 1'b0;
                                    state_next     = S_WR_CHECK;
                                end
                            end
                        end
                        K_READ: begin
                            if (q_rdata.status != ST_OK) begin
                                state_next = S_EMIT;
                            end else begin
                                r_next     = newest_reg;
                                guard_next = '0;
                                state_next = S_RD_VA_W;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ret_reg;
                end
            end
            // read walk, newest entry first
            S_RD_VA_W: begin
                if (hw == RSVD_LOW || guard_reg >= GW'(PAGE_HALFWORDS)) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_EMIT;
                end else begin
                    guard_next = guard_reg + 1'b1;
                    match_next = hw == cmd_reg.vaddress;
                    rd_off     = r_of + OFW'(1);
                    state_next = S_RD_HD_W;
                end
            end
            S_RD_HD_W: begin
                lp = hw[7:0];
                if (match_reg) begin
                    if (hw[15:8] != cmd_reg.size_bytes) begin
                        res_st_next = ST_MISMATCH;
                        state_next  = S_EMIT;
                    end else if (n_cmd == 8'd0) begin
                        res_st_next = ST_OK;
                        state_next  = S_EMIT;
                    end else begin
                        idx_next   = '0;
                        rd_off     = r_of + OFW'(2);
                        state_next = S_RD_WD_W;
                    end
                end else if (lp == 8'd0 || OFW'(lp) > r_of) begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_EMIT;
                end else begin
                    r_next     = OW'(r_of - OFW'(lp));
                    rd_off     = r_of - OFW'(lp);
                    state_next = S_RD_VA_W;
                end
            end
            S_RD_ISSUE: begin
                rd_off     = r_of + OFW'(2) + OFW'(idx_reg);
                state_next = S_RD_WD_W;
            end
            S_RD_WD_W: begin
                res_st_next   = ST_OK;
                res_word_next = word_m;
                res_fin_next  = idx_reg == n_cmd - 8'd1;
                idx_next      = idx_reg + 8'd1;
                ret_next      = (idx_reg == n_cmd - 8'd1) ? S_IDLE : S_RD_ISSUE;
                state_next    = S_EMIT;
            end
            // append an entry
            S_WR_CHECK: begin
                if (OFW'(free_reg) + OFW'(n_cmd) + OFW'(2) <= PAGE_OF) begin
                    idx_next   = '0;
                    state_next = S_WR_BUF;
                end else if (!compacted_reg) begin
                    compacted_next = 1'b1;
                    state_next     = S_CP_MARK;
                end else begin
                    res_st_next = ST_FULL;
                    state_next  = S_EMIT;
                end
            end
            S_WR_BUF: begin
                if (idx_reg == n_cmd) begin
                    state_next = S_WR_HDR1;
                end else begin
                    state_next = S_WR_DATA;
                end
            end
            S_WR_DATA: begin
                wr_en      = 1'b1;
                wr_off     = OFW'(free_reg) + OFW'(2) + OFW'(idx_reg);
                wr_data    = buf_q_reg;
                idx_next   = idx_reg + 8'd1;
                buf_raddr  = idx_next[WBW-1:0];
                state_next = S_WR_BUF;
            end
            S_WR_HDR1: begin
                wr_en      = 1'b1;
                wr_off     = OFW'(free_reg) + OFW'(1);
                wr_data    = {cmd_reg.size_bytes, 8'(free_reg - FW'(newest_reg))};
                state_next = S_WR_HDR0;
            end
            S_WR_HDR0: begin
                wr_en       = 1'b1;
                wr_off      = OFW'(free_reg);
                wr_data     = cmd_reg.vaddress;
                newest_next = OW'(free_reg);
                free_next   = FW'(OFW'(free_reg) + OFW'(n_cmd) + OFW'(2));
                res_st_next = ST_OK;
                state_next  = S_EMIT;
            end
            // compaction onto the other page
            S_CP_MARK: begin
                wr_en      = 1'b1;
                wr_page    = !active_reg;
                wr_off     = OFW'(2);
                wr_data    = RECEIVE_MARK;
                wprev_next = '0;
                wptr_next  = FW'(4);
                r_next     = newest_reg;
                guard_next = '0;
                state_next = S_CP_VA_W;
            end
            S_CP_VA_W: begin
                if (hw == RSVD_LOW || guard_reg >= GW'(PAGE_HALFWORDS)) begin
                    sweep_next = '0;
                    state_next = S_CP_FMT;
                end else begin
                    vac_next   = hw;
                    guard_next = guard_reg + 1'b1;
                    rd_off     = r_of + OFW'(1);
                    state_next = S_CP_HD_W;
                end
            end
            S_CP_HD_W: begin
                hdrc_next  = hw;
                s_next     = OFW'(4);
                state_next = S_CP_SRCH;
            end
            S_CP_SRCH: begin
                rd_page = !active_reg;
                rd_off  = s_reg;
                if (s_reg < OFW'(wptr_reg)) begin
                    state_next = S_CP_SRCH_VA_W;
                end else begin
                    idx_next   = '0;
                    state_next = S_CP_COPY_RD;
                end
            end
            S_CP_SRCH_VA_W: begin
                if (hw == vac_reg) begin
                    state_next = S_CP_LINK;
                end else begin
                    rd_page    = !active_reg;
                    rd_off     = s_reg + OFW'(1);
                    state_next = S_CP_SRCH_HD_W;
                end
            end
            S_CP_SRCH_HD_W: begin
                s_next = s_reg + OFW'(2) + OFW'((9'(hw[15:8]) + 9'd1) >> 1);
                state_next = S_CP_SRCH;
            end
            S_CP_COPY_RD: begin
                rd_off = r_of + OFW'(2) + OFW'(idx_reg);
                if (idx_reg == n_c) begin
                    state_next = S_CP_HDR1;
                end else begin
                    state_next = S_CP_COPY_W;
                end
            end
            S_CP_COPY_W: begin
                wr_en      = 1'b1;
                wr_page    = !active_reg;
                wr_off     = OFW'(wptr_reg) + OFW'(2) + OFW'(idx_reg);
                wr_data    = hw;
                idx_next   = idx_reg + 8'd1;
                state_next = S_CP_COPY_RD;
            end
            S_CP_HDR1: begin
                wr_en      = 1'b1;
                wr_page    = !active_reg;
                wr_off     = OFW'(wptr_reg) + OFW'(1);
                wr_data    = {hdrc_reg[15:8], 8'(wptr_reg - FW'(wprev_reg))};
                state_next = S_CP_HDR0;
            end
            S_CP_HDR0: begin
                wr_en      = 1'b1;
                wr_page    = !active_reg;
                wr_off     = OFW'(wptr_reg);
                wr_data    = vac_reg;
                wprev_next = OW'(wptr_reg);
                wptr_next  = FW'(OFW'(wptr_reg) + OFW'(n_c) + OFW'(2));
                state_next = S_CP_LINK;
            end
            S_CP_LINK: begin
                if (lp == 8'd0 || OFW'(lp) > r_of) begin
                    sweep_next = '0;
                    state_next = S_CP_FMT;
                end else begin
                    r_next     = OW'(r_of - OFW'(lp));
                    rd_off     = r_of - OFW'(lp);
                    state_next = S_CP_VA_W;
                end
            end
            // reformat the old page, one halfword a cycle
            S_CP_FMT: begin
                wr_en  = 1'b1;
                wr_off = OFW'(sweep_reg);
                if (sweep_reg == OW'(0)) begin
                    wr_data = RSVD_LOW;
                end else if (sweep_reg == OW'(1)) begin
                    wr_data = DUMMY_LINK;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == OW'(PAGE_HALFWORDS - 1)) begin
                    sweep_next = '0;
                    state_next = S_CP_VALID;
                end
            end
            S_CP_VALID: begin
                wr_en       = 1'b1;
                wr_page     = !active_reg;
                wr_off      = OFW'(3);
                wr_data     = VALID_MARK;
                active_next = !active_reg;
                newest_next = wprev_reg;
                free_next   = wptr_reg;
                state_next  = S_WR_CHECK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/flash_log_variable_store.sv =====
// top level of the flash log variable store
//
// channel  dir  tdata                                       tuser        tlast
// s_       in   vaddress[15:0] size_bytes[23:16]            cmd          last
//               data_word[39:24]
// m_       out  read_word[15:0]                             status[2:0]  final_res
//
// after reset a clearing pass formats both pages; no word is taken during it
// a read walks back entry by entry from the newest, then emits each result halfword
// a committing write stores the data halfwords, then the two header halfwords; a
// compaction copies each source entry whose vaddress the destination page lacks,
// searching the destination entries for it, then reformats the old page, all bound
// by the single page store port pair
// the command queue lets the input side run ahead while the sequencer or the
// output register is stalled
`default_nettype none
module flash_log_variable_store
    import flvs_pkg::*;
#(
    parameter int PAGE_HALFWORDS  = 512,
    parameter int MAX_VALUE_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // vaddress, size_bytes, data_word
    input  wire logic        s_tuser,   // cmd
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_word
    output logic [2:0]       m_tuser,   // status
    output logic             m_tlast
);

    back_stat_t back_stat;
    cmd_t       q_wdata, q_rdata;
    logic       q_push, q_pop, q_full, q_empty;

    flvs_front #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .back_stat(back_stat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    flvs_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .full   (q_full),
        .empty  (q_empty)
    );

    flvs_back #(
        .PAGE_HALFWORDS (PAGE_HALFWORDS),
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .back_stat(back_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
